FILE: hw/rtl/signed_integer_to_radix_text_assert.svh
// Assertion macros for the radix text converter.
// No dependencies; included by the top level only.
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`ifndef SYNTHESIS
// Check that prop holds at every rising clock edge outside reset.
`define SIRT_ASSERT(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error("sirt: assertion failed");
// Check that cond is never true outside reset.
`define SIRT_NEVER(label, clk_sig, rst_sig, cond) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) \
        else $error("sirt: forbidden condition seen");
`else
`define SIRT_ASSERT(label, clk_sig, rst_sig, prop)
`define SIRT_NEVER(label, clk_sig, rst_sig, cond)
`endif
`endif

FILE: hw/rtl/sirt_pkg.sv
// Shared types, constants and helpers of the radix text converter.
// No dependencies; used by the channel interfaces, the front, back and top modules and the bench.
`timescale 1ns / 1ps

package sirt_pkg;

    localparam int NUMBER_W = 32;
    localparam int RADIX_W  = 6;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 6;

    // quotient bits resolved per divider cycle
    localparam int DIV_STEP_BITS = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;

    typedef struct packed {
        logic               neg;
        logic               bad_radix;
        logic [RADIX_W-1:0] radix;
    } job_flags_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        if (d < 6'd10)
        begin
            return CH_ZERO + CHAR_W'(d);
        end
        return CH_LOWER_A + CHAR_W'(d) - 8'd10;
    endfunction

endpackage

FILE: hw/rtl/sirt_channels.sv
// Valid/ready channel interfaces: value in, text out, radix write.
// Depends on sirt_pkg.
`timescale 1ns / 1ps

interface sirt_value_if;
    import sirt_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [NUMBER_W-1:0] number;
    modport source (output valid, output number, input ready);
    modport sink (input valid, input number, output ready);
endinterface

interface sirt_text_if;
    import sirt_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              final_char;
    logic              empty_text;
    modport source (output valid, output text_char, output final_char,
                    output empty_text, input ready);
    modport sink (input valid, input text_char, input final_char,
                  input empty_text, output ready);
endinterface

interface sirt_cfg_if;
    import sirt_pkg::*;
    logic               valid;
    logic               ready;
    logic [RADIX_W-1:0] radix;
    modport source (output valid, output radix, input ready);
    modport sink (input valid, input radix, output ready);
endinterface

FILE: hw/rtl/signed_integer_to_radix_text.sv
// Top level of the signed integer to radix text converter.
// Depends on sirt_pkg, sirt_channels, sirt_front, sirt_fifo, sirt_back, sirt_ram
// and the assertion header.
`timescale 1ns / 1ps

//  channel | dir | word                                   | handshake
//  --------+-----+----------------------------------------+-----------
//  cfg     | in  | radix (6b)                             | valid/ready
//  value   | in  | number (32b signed)                    | valid/ready
//  text    | out | text_char (8b), final_char, empty_text | valid/ready
//
// Each digit is computed in the divider (4 quotient bits per cycle), then
// each character passes through the digit stack read port (S_RD, then S_LOAD).
// The worst case is a 32-bit value in base 2: 32 digits plus the sign.
// A bad radix gives its single empty word from S_EMPTY after dequeue.
// Reset sets the radix to 10 and empties the queue; the stack needs no clear.
// The two-entry queue keeps taking value words while text output stalls, until it is full.

module signed_integer_to_radix_text #(
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    sirt_cfg_if.sink    cfg,
    sirt_value_if.sink  value,
    sirt_text_if.source text
);
    import sirt_pkg::*;

`include "signed_integer_to_radix_text_assert.svh"

    localparam int JOB_W = $bits(job_flags_t) + VALUE_BITS;

    logic [RADIX_W-1:0]    radix_reg;
    logic                  push_valid;
    job_flags_t            push_flags;
    logic [VALUE_BITS-1:0] push_mag;
    logic                  queue_full;
    logic                  pop;
    logic                  pop_valid;
    logic [JOB_W-1:0]      pop_data;
    job_flags_t            pop_flags;
    logic [VALUE_BITS-1:0] pop_mag;

    // radix register: always writable, held per job in the queue
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg.valid)
        begin
            radix_reg <= cfg.radix;
        end
    end

    // classify on accept
    sirt_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .value      (value),
        .radix      (radix_reg),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_flags (push_flags),
        .push_mag   (push_mag)
    );

    // hold classified jobs between the two halves
    sirt_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data ({push_flags, push_mag}),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    assign pop_flags = pop_data[JOB_W-1:VALUE_BITS];
    assign pop_mag   = pop_data[VALUE_BITS-1:0];

    // divide, stack digits, emit characters
    sirt_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_flags (pop_flags),
        .job_mag   (pop_mag),
        .job_pop   (pop),
        .text      (text)
    );

    // an empty word closes its text and carries no character
    `SIRT_ASSERT(a_empty_is_final, clk, rst_n,
        (text.valid && text.empty_text) |-> (text.final_char && text.text_char == CH_NUL))

    // a sign never ends the text
    `SIRT_NEVER(a_minus_not_final, clk, rst_n,
        text.valid && text.text_char == CH_MINUS && text.final_char)

    // every non-empty word is a sign, a decimal digit or a lower-case letter
    `SIRT_ASSERT(a_char_set, clk, rst_n,
        (text.valid && !text.empty_text) |-> (text.text_char == CH_MINUS
        || (text.text_char >= CH_ZERO && text.text_char <= CH_NINE)
        || (text.text_char >= CH_LOWER_A && text.text_char <= CH_LOWER_Z)))

endmodule

FILE: hw/rtl/sirt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sirt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/sirt_front.sv
// Front end: accept a value word, take its magnitude and sign, check the radix.
// Depends on sirt_pkg and sirt_channels.
`timescale 1ns / 1ps

module sirt_front #(
    parameter int VALUE_BITS = 32
) (
    sirt_value_if.sink                    value,
    input  logic [sirt_pkg::RADIX_W-1:0]  radix,
    input  logic                          queue_full,
    output logic                          push_valid,
    output sirt_pkg::job_flags_t          push_flags,
    output logic [VALUE_BITS-1:0]         push_mag
);
    import sirt_pkg::*;

    logic [VALUE_BITS-1:0] raw;

    // keep the low VALUE_BITS bits, zero-filled when the field is narrower
    assign raw = VALUE_BITS'($unsigned(value.number));

    assign value.ready = !queue_full;
    assign push_valid  = value.valid && !queue_full;

    assign push_flags.neg       = raw[VALUE_BITS-1];
    assign push_flags.bad_radix = (radix < RADIX_MIN) || (radix > RADIX_MAX);
    assign push_flags.radix     = radix;
    // the most negative value negates to itself, which is its exact magnitude
    assign push_mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

endmodule

FILE: hw/rtl/sirt_fifo.sv
// Short job queue between front and back end.
// No dependencies.
`timescale 1ns / 1ps

module sirt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/sirt_back.sv
// Back end: repeated division by the radix, digit stack, character output.
// Depends on sirt_pkg, sirt_channels and sirt_ram.
`timescale 1ns / 1ps

module sirt_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  sirt_pkg::job_flags_t  job_flags,
    input  logic [VALUE_BITS-1:0] job_mag,
    output logic                  job_pop,
    sirt_text_if.source           text
);
    import sirt_pkg::*;

    localparam int STEPS    = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int PAD_BITS = STEPS * DIV_STEP_BITS;
    localparam int STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int ADDR_W   = $clog2(VALUE_BITS);
    localparam int CNT_W    = $clog2(VALUE_BITS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_EMPTY = 6'b000100,
        S_SIGN  = 6'b001000,
        S_RD    = 6'b010000,
        S_LOAD  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [PAD_BITS-1:0]  work_reg, work_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]     nd_reg, nd_next;
    logic                 neg_reg, neg_next;
    logic [RADIX_W-1:0]   radix_reg, radix_next;

    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 final_reg, final_next;
    logic                 empty_reg, empty_next;
    logic                 out_free;

    logic [PAD_BITS-1:0]  div_work;
    logic [DIGIT_W-1:0]   div_rem;

    logic                 wr_en, rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [DIGIT_W-1:0]   rd_data;
    logic [CNT_W-1:0]     nd_less;

    // restoring division, DIV_STEP_BITS quotient bits per cycle;
    // the remainder stays below the radix so the trial fits in 7 bits
    always_comb
    begin
        logic [DIGIT_W:0]    trial;
        logic [DIGIT_W-1:0]  r;
        logic [PAD_BITS-1:0] w;
        r = rem_reg;
        w = work_reg;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            trial = {r, w[PAD_BITS-1]};
            w     = {w[PAD_BITS-2:0], 1'b0};
            if (trial >= {1'b0, radix_reg})
            begin
                r    = DIGIT_W'(trial - {1'b0, radix_reg});
                w[0] = 1'b1;
            end
            else
            begin
                r = trial[DIGIT_W-1:0];
            end
        end
        div_work = w;
        div_rem  = r;
    end

    assign out_free = !out_valid_reg || text.ready;
    assign nd_less  = nd_reg - 1'b1;
    assign rd_addr  = nd_less[ADDR_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        nd_next        = nd_reg;
        neg_next       = neg_reg;
        radix_next     = radix_reg;
        out_valid_next = out_valid_reg && !text.ready;
        char_next      = char_reg;
        final_next     = final_reg;
        empty_next     = empty_reg;
        job_pop        = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                job_pop = 1'b1;
                if (job_valid)
                begin
                    radix_next = job_flags.radix;
                    neg_next   = job_flags.neg;
                    work_next  = PAD_BITS'(job_mag);
                    rem_next   = '0;
                    step_next  = '0;
                    nd_next    = '0;
                    state_next = job_flags.bad_radix ? S_EMPTY : S_DIV;
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CH_NUL;
                    final_next     = 1'b1;
                    empty_next     = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIV:
            begin
                work_next = div_work;
                rem_next  = div_rem;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    // digit done: push it, go again on the quotient
                    wr_en     = 1'b1;
                    nd_next   = nd_reg + 1'b1;
                    rem_next  = '0;
                    step_next = '0;
                    if (div_work == '0)
                    begin
                        state_next = neg_reg ? S_SIGN : S_RD;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CH_MINUS;
                    final_next     = 1'b0;
                    empty_next     = 1'b0;
                    state_next     = S_RD;
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_char(rd_data);
                    final_next     = (nd_reg == CNT_W'(1));
                    empty_next     = 1'b0;
                    nd_next        = nd_less;
                    state_next     = (nd_reg == CNT_W'(1)) ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        nd_reg    <= nd_next;
        neg_reg   <= neg_next;
        radix_reg <= radix_next;
        char_reg  <= char_next;
        final_reg <= final_next;
        empty_reg <= empty_next;
    end

    sirt_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(VALUE_BITS)
    ) u_digit_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (nd_reg[ADDR_W-1:0]),
        .wr_data (div_rem),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign text.valid      = out_valid_reg;
    assign text.text_char  = char_reg;
    assign text.final_char = final_reg;
    assign text.empty_text = empty_reg;

endmodule

FILE: tb/sv/signed_integer_to_radix_text_tb.sv
// Self-checking bench for the signed integer to radix text converter.
// Depends on sirt_pkg, the sirt channel interfaces and the converter top level.
`timescale 1ns / 1ps

module signed_integer_to_radix_text_tb;

    import sirt_pkg::*;

    // One output word: a character with its end and empty flags.
    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              final_char;
        logic              empty_text;
    } text_word_t;

    localparam string DIGIT_SET     = "0123456789abcdefghijklmnopqrstuvwxyz";
    localparam int    SETTLE_CYCLES = 120;        // quiet gap after the last word of a phase
    localparam int    HOLD_CYCLES   = 400;        // long receiver hold-off
    localparam int    CYCLE_LIMIT   = 2_000_000;
    localparam int    RANDOM_PHASES = 12;
    localparam int    PHASE_ITEMS   = 37;

    logic clk;
    logic rst_n;

    sirt_cfg_if   cfg_ch ();
    sirt_value_if value_ch ();
    sirt_text_if  text_ch ();

    signed_integer_to_radix_text #(
        .VALUE_BITS(NUMBER_W)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_ch),
        .value(value_ch),
        .text (text_ch)
    );

    // Bench copy of the radix register and the words still owed by the block.
    logic [RADIX_W-1:0]  radix_model = RADIX_RESET;
    text_word_t          expected_text[$];
    logic [NUMBER_W-1:0] pending_numbers[$];
    text_word_t          want_word;

    // Handshake counters: bumped at the rising edge, read by the falling-edge drivers.
    int numbers_queued = 0;
    int numbers_taken  = 0;
    int numbers_seen   = 0;
    int chars_taken    = 0;
    int chars_seen     = 0;
    int radix_writes   = 0;
    int number_gap     = 0;
    int char_stall     = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    // Idling controls, set per phase by the stimulus process; text_hold is driven by the hold-off process.
    logic value_idle_on = 1'b1;
    logic text_idle_on  = 1'b1;
    logic hold_go       = 1'b0;
    logic text_hold     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Expand one number into the character words the block must produce,
    // using the radix currently held in the bench register copy.
    function automatic void predict_text(input logic [NUMBER_W-1:0] num);
        logic [NUMBER_W-1:0] mag;
        logic [NUMBER_W-1:0] base;
        logic [CHAR_W-1:0]   digits[$];
        int                  n;
        if (radix_model < RADIX_MIN || radix_model > RADIX_MAX)
        begin
            // bad radix: one empty word and nothing else
            expected_text.push_back('{text_char: CH_NUL, final_char: 1'b1, empty_text: 1'b1});
            return;
        end
        base = NUMBER_W'(radix_model);
        // exact magnitude; the most negative value wraps to 2^31 as unsigned
        mag = num[NUMBER_W-1] ? (~num + 1'b1) : num;
        do
        begin
            digits.push_front(DIGIT_SET[int'(mag % base)]);
            mag = mag / base;
        end
        while (mag != 0);
        if (num[NUMBER_W-1])
        begin
            expected_text.push_back('{text_char: CH_MINUS, final_char: 1'b0, empty_text: 1'b0});
        end
        n = digits.size();
        foreach (digits[i])
        begin
            expected_text.push_back('{text_char: digits[i], final_char: (i == n - 1),
                                      empty_text: 1'b0});
        end
    endfunction

    function automatic int draw_gap(input logic on);
        return on ? int'($urandom_range(0, 15)) : 0;
    endfunction

    // Pick a number that stresses the conversion: small values, the two extremes,
    // powers of the radix and their neighbors, and plain random words.
    function automatic logic [NUMBER_W-1:0] pick_number(input logic [RADIX_W-1:0] r);
        logic [NUMBER_W-1:0] p;
        int                  k;
        case ($urandom_range(0, 7))
            0: return NUMBER_W'($urandom_range(0, 40));
            1: return -NUMBER_W'($urandom_range(0, 40));
            2: return 32'h7fff_ffff - NUMBER_W'($urandom_range(0, 15));
            3: return 32'h8000_0000 + NUMBER_W'($urandom_range(0, 15));
            4:
            begin
                if (r < RADIX_MIN)
                begin
                    return $urandom();
                end
                p = 1;
                k = $urandom_range(1, 31);
                repeat (k)
                begin
                    if (p <= 32'h7fff_ffff / NUMBER_W'(r))
                    begin
                        p = p * NUMBER_W'(r);
                    end
                end
                p = p - NUMBER_W'($urandom_range(0, 1));
                return $urandom_range(0, 1) ? p : -p;
            end
            default: return $urandom();
        endcase
    endfunction

    // Rising edge: record every handshake in one process so that prediction
    // and checking see a consistent order within the time step.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                radix_model = cfg_ch.radix;
                radix_writes++;
            end
            if (value_ch.valid && value_ch.ready)
            begin
                predict_text(value_ch.number);
                numbers_taken++;
            end
            if (text_ch.valid && text_ch.ready)
            begin
                chars_taken++;
                if (expected_text.size() == 0)
                begin
                    $display("%0t: unexpected word char=%h final=%b empty=%b", $time,
                             text_ch.text_char, text_ch.final_char, text_ch.empty_text);
                    fail_count++;
                end
                else
                begin
                    want_word = expected_text.pop_front();
                    if (text_ch.text_char !== want_word.text_char)
                    begin
                        $display("%0t: text_char expected %h actual %h", $time,
                                 want_word.text_char, text_ch.text_char);
                        fail_count++;
                    end
                    if (text_ch.final_char !== want_word.final_char)
                    begin
                        $display("%0t: final_char expected %b actual %b", $time,
                                 want_word.final_char, text_ch.final_char);
                        fail_count++;
                    end
                    if (text_ch.empty_text !== want_word.empty_text)
                    begin
                        $display("%0t: empty_text expected %b actual %b", $time,
                                 want_word.empty_text, text_ch.empty_text);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Number driver: drop valid once the word is taken, wait out the drawn
    // gap, then offer the next pending number. Valid gets one assignment per edge.
    always @(negedge clk)
    begin : number_driver
        logic                next_valid;
        logic [NUMBER_W-1:0] next_number;
        next_valid  = value_ch.valid;
        next_number = value_ch.number;
        if (!rst_n)
        begin
            next_valid  = 1'b0;
            next_number = '0;
        end
        else
        begin
            if (next_valid && numbers_taken != numbers_seen)
            begin
                numbers_seen = numbers_taken;
                next_valid   = 1'b0;
            end
            if (!next_valid)
            begin
                if (number_gap != 0)
                begin
                    number_gap--;
                end
                else if (pending_numbers.size() != 0)
                begin
                    next_number = pending_numbers.pop_front();
                    next_valid  = 1'b1;
                    number_gap  = draw_gap(value_idle_on);
                end
            end
        end
        value_ch.valid  <= next_valid;
        value_ch.number <= next_number;
    end

    // Text receiver: draw a stall after each taken word; the long hold-off
    // overrides everything while it runs.
    always @(negedge clk)
    begin
        if (chars_taken != chars_seen)
        begin
            chars_seen = chars_taken;
            char_stall = draw_gap(text_idle_on);
        end
        else if (char_stall != 0)
        begin
            char_stall--;
        end
        text_ch.ready <= rst_n && !text_hold && char_stall == 0;
    end

    // Long hold-off on the text side: the sender keeps offering numbers, so
    // the input queue fills and the block must stall its value channel.
    initial
    begin
        wait (hold_go);
        @(negedge clk);
        text_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        text_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d words outstanding", $time, expected_text.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Queue a number for the driver; fill at the rising edge so the
    // falling-edge driver never races the push.
    task automatic queue_number(input logic [NUMBER_W-1:0] num);
        pending_numbers.push_back(num);
        numbers_queued++;
    endtask

    // Hold until every queued number is taken and every word has come back,
    // then let the block settle before the radix may change.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (numbers_taken != numbers_queued || expected_text.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        int start;
        @(negedge clk);
        start = radix_writes;
        cfg_ch.valid <= 1'b1;
        cfg_ch.radix <= r;
        do
            @(negedge clk);
        while (radix_writes == start);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [RADIX_W-1:0] phase_radix[RANDOM_PHASES];
        logic [RADIX_W-1:0] r;
        cfg_ch.valid    = 1'b0;
        cfg_ch.radix    = RADIX_RESET;
        rst_n           = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, at the reset radix of ten: zero, signs, both extremes,
        // carries across digit boundaries.
        @(posedge clk);
        queue_number(32'd0);
        queue_number(32'd1);
        queue_number(-32'd1);
        queue_number(32'h7fff_ffff);
        queue_number(32'h8000_0000);
        queue_number(32'd9);
        queue_number(32'd10);
        queue_number(-32'd10);
        queue_number(32'd123456789);
        queue_number(32'h5555_5555);
        queue_number(32'haaaa_aaaa);
        wait_idle();

        // Smallest radix: the longest text, 32 digits plus the sign.
        write_radix(RADIX_MIN);
        @(posedge clk);
        queue_number(32'h8000_0000);
        queue_number(32'h7fff_ffff);
        queue_number(-32'd1);
        queue_number(32'd0);
        queue_number(32'd1);
        wait_idle();

        // Largest radix: the top digit 'z' and a carry past it.
        write_radix(RADIX_MAX);
        @(posedge clk);
        queue_number(32'h8000_0000);
        queue_number(32'h7fff_ffff);
        queue_number(32'd35);
        queue_number(32'd36);
        queue_number(-32'd35);
        wait_idle();

        // Bad radix on both sides of the valid range.
        write_radix(6'd0);
        @(posedge clk);
        queue_number(32'd5);
        wait_idle();
        write_radix(6'd63);
        @(posedge clk);
        queue_number(-32'd7);
        wait_idle();

        // Random phases: the extremes and both bad-radix edges first, then
        // random radixes that mostly fall in the valid range.
        phase_radix = '{6'd2, 6'd36, 6'd16, 6'd0, 6'd10, 6'd63, 6'd1, 6'd37,
                        6'd3, 6'd35, 6'd8, 6'd7};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            r = phase_radix[p];
            if (p >= 10)
            begin
                r = ($urandom_range(0, 5) == 0) ? RADIX_W'($urandom_range(0, 63))
                                                : RADIX_W'($urandom_range(2, 36));
            end
            write_radix(r);
            // keep the sender busy during the receiver hold-off
            value_idle_on <= (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            text_idle_on  <= $urandom_range(0, 3) != 0;
            if (p == 2)
            begin
                hold_go <= 1'b1;
            end
            @(posedge clk);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                queue_number(pick_number(r));
            end
            wait_idle();
        end

        if (expected_text.size() != 0)
        begin
            $display("%0t: %0d words never arrived", $time, expected_text.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/sirt_pkg.sv
hw/rtl/sirt_channels.sv
hw/rtl/sirt_ram.sv
hw/rtl/sirt_front.sv
hw/rtl/sirt_fifo.sv
hw/rtl/sirt_back.sv
hw/rtl/signed_integer_to_radix_text.sv
tb/sv/signed_integer_to_radix_text_tb.sv
